/* src/tivs_pkg.sv */
// package for the trapped-ion verlet step block
// types, constants and fixed point helpers; no dependencies
`default_nettype none
package tivs_pkg;
	localparam int NUM_IONS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_MASS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIAL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AXIAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PUSH_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PUSH_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PUSH_Z = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 3'd7;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_STEP = 1'b1;

	// input and result transfers
	typedef struct packed {
		logic               action;
		logic [IDX_W-1:0]   ion_index;
		logic signed [31:0] value_x;
		logic signed [31:0] value_y;
		logic signed [31:0] value_z;
	} ion_cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]   out_index;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} ion_pos_t;

	// datapath multiplier operand selects
	typedef enum logic [2:0] {
		OP_V_DT, OP_A_DT, OP_AD_DT, OP_GAIN_X, OP_DAMP_V, OP_F_IM, OP_AV_DT
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_LOAD, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
		ST_M6, ST_WB, ST_OUT
	} state_t;

	typedef struct packed {
		logic  cap_in;
		logic  mul_go;
		op_t   op;
		logic  wr_load;
		logic  wr_step;
		logic  clr_out;
		logic  axis_next;
		logic  axis_rst;
		logic  out_set;
	} cmd_t;

	typedef struct packed {
		logic       last_axis;
		logic       idx_ok;
		logic       is_step;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

/* src/tivs_if.sv */
// valid/ready channel interface with a generic payload
// depends on nothing
`default_nettype none
interface tivs_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/tivs_ram.sv */
// generic single port ram with registered read
// depends on nothing
`default_nettype none
module tivs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

/* src/tivs_ctrl.sv */
// controller state machine of the verlet step
// depends on tivs_pkg
`default_nettype none
module tivs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire tivs_pkg::sts_t sts,
	output tivs_pkg::cmd_t      cmd
);
	tivs_pkg::state_t state_q, state_d;
	logic out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			tivs_pkg::ST_IDLE: if (in_valid && !out_valid_q) state_d = tivs_pkg::ST_READ;
			tivs_pkg::ST_READ: begin
				if (!sts.idx_ok) state_d = tivs_pkg::ST_OUT;
				else if (sts.is_step) state_d = tivs_pkg::ST_M0;
				else state_d = tivs_pkg::ST_LOAD;
			end
			tivs_pkg::ST_LOAD: state_d = sts.last_axis ? tivs_pkg::ST_OUT : tivs_pkg::ST_READ;
			tivs_pkg::ST_M0: state_d = tivs_pkg::ST_M1;
			tivs_pkg::ST_M1: state_d = tivs_pkg::ST_M2;
			tivs_pkg::ST_M2: state_d = tivs_pkg::ST_M3;
			tivs_pkg::ST_M3: state_d = tivs_pkg::ST_M4;
			tivs_pkg::ST_M4: state_d = tivs_pkg::ST_M5;
			tivs_pkg::ST_M5: state_d = tivs_pkg::ST_M6;
			tivs_pkg::ST_M6: state_d = tivs_pkg::ST_WB;
			tivs_pkg::ST_WB: state_d = sts.last_axis ? tivs_pkg::ST_OUT : tivs_pkg::ST_READ;
			tivs_pkg::ST_OUT: state_d = tivs_pkg::ST_IDLE;
			default: state_d = tivs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.op = tivs_pkg::OP_V_DT;
		case (state_q)
			tivs_pkg::ST_IDLE: begin
				cmd.cap_in = in_valid && !out_valid_q;
				cmd.axis_rst = 1'b1;
				cmd.clr_out = in_valid && !out_valid_q;
			end
			tivs_pkg::ST_LOAD: begin cmd.wr_load = 1'b1; cmd.axis_next = 1'b1; end
			tivs_pkg::ST_M0: begin cmd.mul_go = 1'b1; cmd.op = tivs_pkg::OP_V_DT; end
			tivs_pkg::ST_M1: begin cmd.mul_go = 1'b1; cmd.op = tivs_pkg::OP_A_DT; end
			tivs_pkg::ST_M2: begin cmd.mul_go = 1'b1; cmd.op = tivs_pkg::OP_AD_DT; end
			tivs_pkg::ST_M3: begin cmd.mul_go = 1'b1; cmd.op = tivs_pkg::OP_GAIN_X; end
			tivs_pkg::ST_M4: begin cmd.mul_go = 1'b1; cmd.op = tivs_pkg::OP_DAMP_V; end
			tivs_pkg::ST_M5: begin cmd.mul_go = 1'b1; cmd.op = tivs_pkg::OP_F_IM; end
			tivs_pkg::ST_M6: begin cmd.mul_go = 1'b1; cmd.op = tivs_pkg::OP_AV_DT; end
			tivs_pkg::ST_WB: begin cmd.wr_step = 1'b1; cmd.axis_next = 1'b1; end
			tivs_pkg::ST_OUT: cmd.out_set = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tivs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_set) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready = (state_q == tivs_pkg::ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

/* src/tivs_dp.sv */
// datapath: state rams, shared multiplier, sums and output register
// depends on tivs_pkg and tivs_ram
`default_nettype none
module tivs_dp #(
	parameter int NUM_IONS = tivs_pkg::NUM_IONS_DEF,
	parameter int FRAC_BITS = tivs_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tivs_pkg::cmd_t                 cmd,
	output tivs_pkg::sts_t                      sts,
	input  wire logic                           in_action,
	input  wire logic [tivs_pkg::IDX_W-1:0]     in_index,
	input  wire logic signed [31:0]             in_x,
	input  wire logic signed [31:0]             in_y,
	input  wire logic signed [31:0]             in_z,
	input  wire logic                           cfg_we,
	input  wire logic [tivs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [tivs_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [tivs_pkg::IDX_W-1:0]          out_index,
	output logic signed [31:0]                  out_x,
	output logic signed [31:0]                  out_y,
	output logic signed [31:0]                  out_z
);
	localparam int DEPTH = NUM_IONS * 3;
	localparam int AW = $clog2(DEPTH);
	localparam int VALID_W = NUM_IONS;

	logic [30:0] dt_q, im_q, damp_q;
	logic signed [31:0] rg_q, ag_q, px_q, py_q, pz_q;
	logic act_q;
	logic [tivs_pkg::IDX_W-1:0] idx_q;
	logic signed [31:0] val_q [3];
	logic [1:0] axis_q;
	logic [VALID_W-1:0] vld_q;
	logic signed [31:0] x_rd, v_rd, a_rd, x_r, v_r, a_r;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] m_q, xn_q, f_q, an_q, vd_q, ad_q;
	logic signed [32:0] mb;
	logic signed [31:0] ma;
	logic signed [65:0] prod, prod_sh;
	logic [AW-1:0] addr;
	logic we_x, we_v;
	logic signed [31:0] wx, wv, wa, gain, push;
	logic idx_ok;

	function automatic logic signed [31:0] sat32v(input logic signed [31:0] d);
		logic signed [65:0] s;
		s = 66'(v_r) + 66'(d);
		return tivs_pkg::sat32(s);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= '0; im_q <= '0; damp_q <= '0;
			rg_q <= '0; ag_q <= '0; px_q <= '0; py_q <= '0; pz_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				tivs_pkg::REG_TIME_STEP: dt_q <= cfg_data[30:0];
				tivs_pkg::REG_INV_MASS:  im_q <= cfg_data[30:0];
				tivs_pkg::REG_RADIAL:    rg_q <= cfg_data;
				tivs_pkg::REG_AXIAL:     ag_q <= cfg_data;
				tivs_pkg::REG_PUSH_X:    px_q <= cfg_data;
				tivs_pkg::REG_PUSH_Y:    py_q <= cfg_data;
				tivs_pkg::REG_PUSH_Z:    pz_q <= cfg_data;
				tivs_pkg::REG_DAMPING:   damp_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			act_q <= in_action;
			idx_q <= in_index;
			val_q[0] <= in_x; val_q[1] <= in_y; val_q[2] <= in_z;
		end
	end

	assign idx_ok = {28'd0, idx_q} < 32'(NUM_IONS);
	assign addr = AW'(({28'd0, idx_q} * 32'd3) + {30'd0, axis_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= '0;
			vld_q <= '0;
		end else begin
			if (cmd.axis_rst) axis_q <= '0;
			else if (cmd.axis_next) axis_q <= axis_q + 2'd1;
			// an ion is valid once its last axis is written
			if ((cmd.wr_load || cmd.wr_step) && axis_q == 2'd2)
				vld_q[idx_q[$clog2(NUM_IONS > 1 ? NUM_IONS : 2)-1:0]] <= 1'b1;
		end
	end

	assign we_x = cmd.wr_load || cmd.wr_step;
	assign we_v = we_x;
	assign wx = cmd.wr_load ? val_q[axis_q] : xn_q;
	assign wv = cmd.wr_load ? 32'sd0 : sat32v(vd_q);
	assign wa = cmd.wr_load ? 32'sd0 : an_q;

	tivs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_xram (
		.clk(clk), .we(we_x), .addr(addr), .wdata(wx), .rdata(x_rd));
	tivs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_vram (
		.clk(clk), .we(we_v), .addr(addr), .wdata(wv), .rdata(v_rd));
	tivs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_aram (
		.clk(clk), .we(we_x), .addr(addr), .wdata(wa), .rdata(a_rd));

	// entries of an ion never written read as zero
	// read data holds while the address stays on one axis
	always_comb begin
		if (vld_q[idx_q[$clog2(NUM_IONS > 1 ? NUM_IONS : 2)-1:0]]) begin
			x_r = x_rd; v_r = v_rd; a_r = a_rd;
		end else begin
			x_r = '0; v_r = '0; a_r = '0;
		end
	end

	assign gain = (axis_q == 2'd2) ? ag_q : rg_q;
	assign push = (axis_q == 2'd0) ? px_q : (axis_q == 2'd1) ? py_q : pz_q;

	always_comb begin
		ma = v_r;
		mb = {2'b00, dt_q};
		case (cmd.op)
			tivs_pkg::OP_V_DT:   begin ma = v_r;  mb = {2'b00, dt_q}; end
			tivs_pkg::OP_A_DT:   begin ma = a_r;  mb = {2'b00, dt_q}; end
			tivs_pkg::OP_AD_DT:  begin ma = m_q;  mb = {2'b00, dt_q}; end
			tivs_pkg::OP_GAIN_X: begin ma = xn_q; mb = {gain[31], gain}; end
			tivs_pkg::OP_DAMP_V: begin ma = v_r;  mb = {2'b00, damp_q}; end
			tivs_pkg::OP_F_IM:   begin ma = f_q;  mb = {2'b00, im_q}; end
			tivs_pkg::OP_AV_DT:  begin ma = ad_q; mb = {2'b00, dt_q}; end
			default: ;
		endcase
	end

	assign prod = 66'(ma) * 66'(mb);
	assign prod_sh = prod >>> FRAC_BITS;

	// the step of the sequence that just finished decides where the product goes
	always_ff @(posedge clk) begin
		if (cmd.mul_go) m_q <= tivs_pkg::sat32(prod_sh);
		if (cmd.mul_go && cmd.op == tivs_pkg::OP_A_DT) vd_q <= m_q;
		if (cmd.mul_go && cmd.op == tivs_pkg::OP_AD_DT)
			xn_q <= tivs_pkg::sat32(66'(x_r) + 66'(vd_q)
				+ 66'(tivs_pkg::sat32(prod_sh) >>> 1));
		if (cmd.mul_go && cmd.op == tivs_pkg::OP_DAMP_V)
			f_q <= tivs_pkg::sat32(66'(m_q) + 66'(val_q[axis_q]) + 66'(push)
				- 66'(tivs_pkg::sat32(prod_sh)));
		if (cmd.mul_go && cmd.op == tivs_pkg::OP_F_IM) begin
			an_q <= tivs_pkg::sat32(prod_sh);
			ad_q <= 32'((33'(a_r) + 33'(tivs_pkg::sat32(prod_sh))) >>> 1);
		end
		if (cmd.mul_go && cmd.op == tivs_pkg::OP_AV_DT) vd_q <= tivs_pkg::sat32(prod_sh);
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_out) begin
			pos_q[0] <= '0; pos_q[1] <= '0; pos_q[2] <= '0;
		end else if (we_x) pos_q[axis_q] <= wx;
	end

	assign out_index = idx_q;
	assign out_x = pos_q[0];
	assign out_y = pos_q[1];
	assign out_z = pos_q[2];

	assign sts.last_axis = (axis_q == 2'd2);
	assign sts.idx_ok = idx_ok;
	assign sts.is_step = (act_q == tivs_pkg::ACT_STEP);
endmodule
`default_nettype wire

/* src/trapped_ion_verlet_step.sv */
// top level of the trapped-ion verlet step
// depends on tivs_pkg, tivs_if, tivs_ctrl, tivs_dp
//   channel | dir | payload
//   in_ch   | in  | action, ion_index, value_x/y/z
//   out_ch  | out | out_index, pos_x/y/z
//   cfg     | in  | cfg_we, cfg_idx, cfg_data
// a load passes READ and LOAD for each axis, a step READ, M0 to M6 and WB (one shared
// multiplier, seven products in sequence), besides the capture in IDLE and the OUT state
// reset clears control, the config registers and the valid flags; ion state reads zero until written
// a waiting result holds the block until it is taken
`default_nettype none
module trapped_ion_verlet_step #(
	parameter int NUM_IONS = tivs_pkg::NUM_IONS_DEF,
	parameter int FRAC_BITS = tivs_pkg::FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	tivs_if.sink                                 in_ch,
	tivs_if.source                               out_ch,
	input  wire logic                            cfg_we,
	input  wire logic [tivs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [tivs_pkg::CFG_DATA_W-1:0] cfg_data
);
	tivs_pkg::cmd_t cmd;
	tivs_pkg::sts_t sts;

	tivs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd));

	tivs_dp #(.NUM_IONS(NUM_IONS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_action(in_ch.data.action), .in_index(in_ch.data.ion_index),
		.in_x(in_ch.data.value_x), .in_y(in_ch.data.value_y),
		.in_z(in_ch.data.value_z),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.out_index(out_ch.data.out_index), .out_x(out_ch.data.pos_x),
		.out_y(out_ch.data.pos_y), .out_z(out_ch.data.pos_z));
endmodule
`default_nettype wire

/* src/tivs_chk.sv */
// port checker for the trapped-ion verlet step, bound to the top level
// depends on the top level ports
`default_nettype none
module tivs_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken with result pending");
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("back to back transfer");
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule
bind trapped_ion_verlet_step tivs_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready));
`default_nettype wire
